// ===== rtl/core/ntc_pkg.sv =====
`timescale 1ns / 1ps
// ntc_pkg: widths, fixed-point constants, register indexes and pipeline types
// for the thermistor beta-equation converter; no dependencies
package ntc_pkg;

   localparam int unsigned CHANNELS = 256;

   // field widths
   localparam int CH_W       = 8;
   localparam int SMP_W      = 23;
   localparam int TEMP_W     = 20;
   localparam int R1_W       = 24;
   localparam int VREF_W     = 23;
   localparam int R25_W      = 24;
   localparam int BETA_W     = 16;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 24;

   // resistance divider, q24.8 result
   localparam int PROD_W      = R1_W + SMP_W;
   localparam int RES_W       = 32;
   localparam int RDIV_STAGES = 8;
   localparam int RDIV_STEPS  = RES_W / RDIV_STAGES;

   // log2 in q5.24
   localparam int EXP_W      = 5;
   localparam int FRAC_W     = 24;
   localparam int LOG_W      = EXP_W + FRAC_W;
   localparam int LOG_STAGES = FRAC_W;
   localparam int LN_W       = LOG_W;
   localparam int LN2_W      = 30;
   localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

   // ln / beta
   localparam int QB_W        = LN_W + BETA_W;
   localparam int BDIV_STAGES = 9;
   localparam int BDIV_STEPS  = QB_W / BDIV_STAGES;

   // reciprocal of 1/T
   localparam int INV_W = 47;
   localparam logic [INV_W-1:0] INV_T0_Q40 = 47'd3687780070;
   localparam int NUM_W = 51;
   localparam logic [NUM_W-1:0] MILLI_Q40 = 51'd1099511627776000;
   localparam int TMK_W       = 20;
   localparam int TDIV_STAGES = 10;
   localparam int TDIV_STEPS  = TMK_W / TDIV_STAGES;
   localparam logic [TMK_W-1:0] TMK_MAX   = 20'd797437;
   localparam logic [TMK_W:0]   ZERO_C_MK = 21'd273150;

   localparam logic signed [TEMP_W-1:0] TEMP_MAX = 20'sd524287;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN = -20'sd273150;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SERIES  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VREF    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_NOMINAL = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BETA    = 8'd3;

   localparam logic [R1_W-1:0]   SERIES_RESET  = 24'd10000;
   localparam logic [VREF_W-1:0] VREF_RESET    = 23'd5000000;
   localparam logic [R25_W-1:0]  NOMINAL_RESET = 24'd10000;
   localparam logic [BETA_W-1:0] BETA_RESET    = 16'd3950;

   typedef enum logic [1:0] {
      ST_VALID = 2'd0,
      ST_OPEN  = 2'd1,
      ST_SHORT = 2'd2
   } status_type;

   typedef struct packed {
      logic             valid;
      logic [CH_W-1:0]  channel;
      status_type       status;
      logic             force_max;
   } ctl_type;

endpackage

// ===== rtl/core/ntc_if.sv =====
`timescale 1ns / 1ps
// ntc_if: valid/ready channel interfaces for sample items, result items and
// register writes; depends on ntc_pkg
interface ntc_req_if;
   logic                         valid;
   logic                         ready;
   logic [ntc_pkg::CH_W-1:0]     channel;
   logic [ntc_pkg::SMP_W-1:0]    sample;
   modport source (output valid, channel, sample, input ready);
   modport sink   (input valid, channel, sample, output ready);
endinterface

interface ntc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [ntc_pkg::CH_W-1:0]         channel_out;
   logic signed [ntc_pkg::TEMP_W-1:0] temperature;
   logic [1:0]                       status;
   modport source (output valid, channel_out, temperature, status, input ready);
   modport sink   (input valid, channel_out, temperature, status, output ready);
endinterface

interface ntc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ntc_pkg::CSR_IDX_W-1:0]     index;
   logic [ntc_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ntc_resist.sv =====
`timescale 1ns / 1ps
// ntc_resist: entry stage and pipelined restoring divider for the thermistor
// resistance in q24.8, saturated; depends on ntc_pkg
module ntc_resist (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [ntc_pkg::CH_W-1:0]      in_channel,
   input  logic [ntc_pkg::SMP_W-1:0]     in_sample,
   input  logic [ntc_pkg::R1_W-1:0]      series_res,
   input  logic [ntc_pkg::VREF_W-1:0]    ref_volt,
   output logic                          entry_free,
   output logic [ntc_pkg::RES_W-1:0]     res_q,
   output ntc_pkg::ctl_type              res_ctl
);

   localparam int LOW_W = ntc_pkg::PROD_W - ntc_pkg::VREF_W;

   logic                                entry_load;
   logic [ntc_pkg::PROD_W-1:0]          prod_ff;
   logic [ntc_pkg::VREF_W-1:0]          den_ff;
   ntc_pkg::ctl_type                    ctl_e_ff;
   ntc_pkg::ctl_type                    ctl_e_in;

   logic [ntc_pkg::VREF_W-1:0]          rem_ff [0:ntc_pkg::RDIV_STAGES-1];
   logic [ntc_pkg::RES_W-1:0]           num_ff [0:ntc_pkg::RDIV_STAGES-1];
   logic [ntc_pkg::RES_W-1:0]           quo_ff [0:ntc_pkg::RDIV_STAGES-1];
   logic [ntc_pkg::VREF_W-1:0]          dvs_ff [0:ntc_pkg::RDIV_STAGES-1];
   logic                                ovf_ff [0:ntc_pkg::RDIV_STAGES-1];
   ntc_pkg::ctl_type                    ctl_ff [0:ntc_pkg::RDIV_STAGES-1];

   // entry stage fills whenever it is empty, even while the rest is stalled
   assign entry_load = adv || !ctl_e_ff.valid;
   assign entry_free = !ctl_e_ff.valid;

   always_comb begin
      ctl_e_in.valid     = in_valid;
      ctl_e_in.channel   = in_channel;
      ctl_e_in.force_max = 1'b0;
      if (in_sample >= ref_volt) begin
         ctl_e_in.status = ntc_pkg::ST_OPEN;
      end else if (in_sample == '0) begin
         ctl_e_in.status = ntc_pkg::ST_SHORT;
      end else begin
         ctl_e_in.status = ntc_pkg::ST_VALID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_e_ff.valid <= 1'b0;
      end else if (entry_load) begin
         ctl_e_ff <= ctl_e_in;
         prod_ff  <= series_res * in_sample;
         den_ff   <= ref_volt - in_sample;
      end
   end

   for (genvar s = 0; s < ntc_pkg::RDIV_STAGES; s++) begin : g_div
      logic [ntc_pkg::VREF_W-1:0] rem_src;
      logic [ntc_pkg::RES_W-1:0]  num_src;
      logic [ntc_pkg::RES_W-1:0]  quo_src;
      logic [ntc_pkg::VREF_W-1:0] dvs_src;
      logic                       ovf_src;
      ntc_pkg::ctl_type           ctl_src;
      logic [ntc_pkg::VREF_W-1:0] rem_in;
      logic [ntc_pkg::RES_W-1:0]  num_in;
      logic [ntc_pkg::RES_W-1:0]  quo_in;

      if (s == 0) begin : g_first
         // top bits of r1*v*256 seed the remainder; quotient past 32 bits saturates
         assign rem_src = prod_ff[ntc_pkg::PROD_W-1 -: ntc_pkg::VREF_W];
         assign num_src = {prod_ff[LOW_W-1:0], 8'b0};
         assign quo_src = '0;
         assign dvs_src = den_ff;
         assign ovf_src = prod_ff[ntc_pkg::PROD_W-1 -: ntc_pkg::VREF_W] >= den_ff;
         assign ctl_src = ctl_e_ff;
      end else begin : g_rest
         assign rem_src = rem_ff[s-1];
         assign num_src = num_ff[s-1];
         assign quo_src = quo_ff[s-1];
         assign dvs_src = dvs_ff[s-1];
         assign ovf_src = ovf_ff[s-1];
         assign ctl_src = ctl_ff[s-1];
      end

      always_comb begin
         logic [ntc_pkg::VREF_W:0] trial;
         rem_in = rem_src;
         num_in = num_src;
         quo_in = quo_src;
         for (int k = 0; k < ntc_pkg::RDIV_STEPS; k++) begin
            trial  = {rem_in, num_in[ntc_pkg::RES_W-1]};
            num_in = {num_in[ntc_pkg::RES_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_src}) begin
               trial  = trial - {1'b0, dvs_src};
               quo_in = {quo_in[ntc_pkg::RES_W-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[ntc_pkg::RES_W-2:0], 1'b0};
            end
            rem_in = trial[ntc_pkg::VREF_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[s] <= ctl_src;
            rem_ff[s] <= rem_in;
            num_ff[s] <= num_in;
            quo_ff[s] <= quo_in;
            dvs_ff[s] <= dvs_src;
            ovf_ff[s] <= ovf_src;
         end
      end
   end

   assign res_q   = ovf_ff[ntc_pkg::RDIV_STAGES-1] ? '1 : quo_ff[ntc_pkg::RDIV_STAGES-1];
   assign res_ctl = ctl_ff[ntc_pkg::RDIV_STAGES-1];

endmodule

// ===== rtl/core/ntc_log.sv =====
`timescale 1ns / 1ps
// ntc_log: two-lane log2 by repeated squaring, one squaring per stage, then
// the difference scaled by ln 2; depends on ntc_pkg
module ntc_log (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [ntc_pkg::RES_W-1:0]     in_res,
   input  ntc_pkg::ctl_type              in_ctl,
   input  logic [ntc_pkg::R25_W-1:0]     nominal,
   output logic [ntc_pkg::LN_W-1:0]      ln_mag,
   output logic                          ln_neg,
   output ntc_pkg::ctl_type              ln_ctl
);

   localparam int LS = ntc_pkg::LOG_STAGES;
   localparam int MW = ntc_pkg::RES_W;
   localparam int FW = ntc_pkg::FRAC_W;

   function automatic logic [ntc_pkg::EXP_W-1:0] lead_one(input logic [MW-1:0] v);
      logic [ntc_pkg::EXP_W-1:0] pos;
      pos = '0;
      for (int i = 0; i < MW; i++) begin
         if (v[i]) begin
            pos = ntc_pkg::EXP_W'(i);
         end
      end
      return pos;
   endfunction

   // index 0 is the normalize stage, 1..LS the squaring stages
   logic [MW-1:0]                 mr_ff [0:LS];
   logic [MW-1:0]                 ma_ff [0:LS];
   logic [FW-1:0]                 fr_ff [0:LS];
   logic [FW-1:0]                 fa_ff [0:LS];
   logic [ntc_pkg::EXP_W-1:0]     pr_ff [0:LS];
   logic [ntc_pkg::EXP_W-1:0]     pa_ff [0:LS];
   ntc_pkg::ctl_type              ctl_ff [0:LS];

   logic [MW-1:0]                 nom_word;
   logic [ntc_pkg::EXP_W-1:0]     pr_in, pa_in;
   ntc_pkg::ctl_type              ctl0_in;

   logic [ntc_pkg::LOG_W:0]       diff;
   logic                          neg_ff;
   logic [ntc_pkg::LN_W-1:0]      mag_ff;
   ntc_pkg::ctl_type              ctl_d_ff;
   logic [ntc_pkg::LN_W+ntc_pkg::LN2_W-1:0] ln_prod;
   logic [ntc_pkg::LN_W-1:0]      ln_ff;
   logic                          ln_neg_ff;
   ntc_pkg::ctl_type              ctl_m_ff;

   assign nom_word = {nominal, 8'b0};
   assign pr_in    = lead_one(in_res);
   assign pa_in    = lead_one(nom_word);

   always_comb begin
      ctl0_in           = in_ctl;
      ctl0_in.force_max = in_ctl.force_max || (in_res == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else if (adv) begin
         ctl_ff[0] <= ctl0_in;
         mr_ff[0]  <= in_res << (5'd31 - pr_in);
         ma_ff[0]  <= nom_word << (5'd31 - pa_in);
         fr_ff[0]  <= '0;
         fa_ff[0]  <= '0;
         pr_ff[0]  <= pr_in;
         pa_ff[0]  <= pa_in;
      end
   end

   for (genvar s = 1; s <= LS; s++) begin : g_sq
      logic [2*MW-1:0] sqr, sqa;
      logic [MW-1:0]   mr_in, ma_in;
      logic [FW-1:0]   fr_in, fa_in;

      assign sqr = mr_ff[s-1] * mr_ff[s-1];
      assign sqa = ma_ff[s-1] * ma_ff[s-1];

      always_comb begin
         if (sqr[2*MW-1]) begin
            mr_in = sqr[2*MW-1 -: MW];
            fr_in = {fr_ff[s-1][FW-2:0], 1'b1};
         end else begin
            mr_in = sqr[2*MW-2 -: MW];
            fr_in = {fr_ff[s-1][FW-2:0], 1'b0};
         end
         if (sqa[2*MW-1]) begin
            ma_in = sqa[2*MW-1 -: MW];
            fa_in = {fa_ff[s-1][FW-2:0], 1'b1};
         end else begin
            ma_in = sqa[2*MW-2 -: MW];
            fa_in = {fa_ff[s-1][FW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else if (adv) begin
            ctl_ff[s] <= ctl_ff[s-1];
            mr_ff[s]  <= mr_in;
            ma_ff[s]  <= ma_in;
            fr_ff[s]  <= fr_in;
            fa_ff[s]  <= fa_in;
            pr_ff[s]  <= pr_ff[s-1];
            pa_ff[s]  <= pa_ff[s-1];
         end
      end
   end

   // signed difference of the two logs, kept as sign and magnitude
   assign diff = {1'b0, pr_ff[LS], fr_ff[LS]} - {1'b0, pa_ff[LS], fa_ff[LS]};
   assign ln_prod = mag_ff * ntc_pkg::LN2_Q30;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d_ff.valid <= 1'b0;
         ctl_m_ff.valid <= 1'b0;
      end else if (adv) begin
         ctl_d_ff  <= ctl_ff[LS];
         neg_ff    <= diff[ntc_pkg::LOG_W];
         mag_ff    <= diff[ntc_pkg::LOG_W] ? ntc_pkg::LN_W'(-diff) : diff[ntc_pkg::LN_W-1:0];
         ctl_m_ff  <= ctl_d_ff;
         ln_neg_ff <= neg_ff;
         ln_ff     <= ln_prod[ntc_pkg::LN_W+ntc_pkg::LN2_W-1 -: ntc_pkg::LN_W];
      end
   end

   assign ln_mag = ln_ff;
   assign ln_neg = ln_neg_ff;
   assign ln_ctl = ctl_m_ff;

endmodule

// ===== rtl/core/ntc_recip.sv =====
`timescale 1ns / 1ps
// ntc_recip: ln/beta divider, 1/T assembly and the pipelined reciprocal that
// yields kelvin in milli-degrees; depends on ntc_pkg
module ntc_recip (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic [ntc_pkg::LN_W-1:0]      ln_mag,
   input  logic                          ln_neg,
   input  ntc_pkg::ctl_type              ln_ctl,
   input  logic [ntc_pkg::BETA_W-1:0]    beta,
   output logic [ntc_pkg::TMK_W-1:0]     tmk,
   output logic                          tmk_ovf,
   output ntc_pkg::ctl_type              tmk_ctl
);

   localparam int BS = ntc_pkg::BDIV_STAGES;
   localparam int TS = ntc_pkg::TDIV_STAGES;
   localparam int QW = ntc_pkg::QB_W;
   localparam int BW = ntc_pkg::BETA_W;
   localparam int DW = ntc_pkg::INV_W - 1;
   localparam int TW = ntc_pkg::TMK_W;
   localparam int HW = ntc_pkg::NUM_W - TW;

   // ln / beta
   logic [BW-1:0]          brem_ff [0:BS-1];
   logic [QW-1:0]          bnum_ff [0:BS-1];
   logic [QW-1:0]          bquo_ff [0:BS-1];
   logic                   bneg_ff [0:BS-1];
   ntc_pkg::ctl_type       bctl_ff [0:BS-1];

   for (genvar s = 0; s < BS; s++) begin : g_bdiv
      logic [BW-1:0]    rem_src;
      logic [QW-1:0]    num_src;
      logic [QW-1:0]    quo_src;
      logic             neg_src;
      ntc_pkg::ctl_type ctl_src;
      logic [BW-1:0]    rem_in;
      logic [QW-1:0]    num_in;
      logic [QW-1:0]    quo_in;

      if (s == 0) begin : g_first
         assign rem_src = '0;
         assign num_src = {ln_mag, {BW{1'b0}}};
         assign quo_src = '0;
         assign neg_src = ln_neg;
         assign ctl_src = ln_ctl;
      end else begin : g_rest
         assign rem_src = brem_ff[s-1];
         assign num_src = bnum_ff[s-1];
         assign quo_src = bquo_ff[s-1];
         assign neg_src = bneg_ff[s-1];
         assign ctl_src = bctl_ff[s-1];
      end

      always_comb begin
         logic [BW:0] trial;
         rem_in = rem_src;
         num_in = num_src;
         quo_in = quo_src;
         for (int k = 0; k < ntc_pkg::BDIV_STEPS; k++) begin
            trial  = {rem_in, num_in[QW-1]};
            num_in = {num_in[QW-2:0], 1'b0};
            if (trial >= {1'b0, beta}) begin
               trial  = trial - {1'b0, beta};
               quo_in = {quo_in[QW-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[QW-2:0], 1'b0};
            end
            rem_in = trial[BW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            bctl_ff[s].valid <= 1'b0;
         end else if (adv) begin
            bctl_ff[s] <= ctl_src;
            brem_ff[s] <= rem_in;
            bnum_ff[s] <= num_in;
            bquo_ff[s] <= quo_in;
            bneg_ff[s] <= neg_src;
         end
      end
   end

   // 1/T in q0.40, then numerator for rounding reciprocal
   logic [ntc_pkg::INV_W-1:0] inv_in;
   logic [ntc_pkg::INV_W-1:0] inv_ff;
   ntc_pkg::ctl_type          ictl_ff;
   ntc_pkg::ctl_type          ictl_in;
   logic [ntc_pkg::NUM_W-1:0] tnum;

   assign inv_in = bneg_ff[BS-1] ? ntc_pkg::INV_T0_Q40 - {2'b0, bquo_ff[BS-1]}
                                 : ntc_pkg::INV_T0_Q40 + {2'b0, bquo_ff[BS-1]};

   always_comb begin
      ictl_in           = bctl_ff[BS-1];
      ictl_in.force_max = bctl_ff[BS-1].force_max || inv_in[DW] || (inv_in == '0);
   end

   assign tnum = ntc_pkg::MILLI_Q40 + ntc_pkg::NUM_W'(inv_ff[DW-1:1]);

   logic [DW-1:0]          trem_ff [0:TS];
   logic [TW-1:0]          tbit_ff [0:TS];
   logic [TW-1:0]          tquo_ff [0:TS];
   logic [DW-1:0]          tdvs_ff [0:TS];
   logic                   tovf_ff [0:TS];
   ntc_pkg::ctl_type       tctl_ff [0:TS];

   always_ff @(posedge clock) begin
      if (reset) begin
         ictl_ff.valid    <= 1'b0;
         tctl_ff[0].valid <= 1'b0;
      end else if (adv) begin
         ictl_ff    <= ictl_in;
         inv_ff     <= inv_in;
         tctl_ff[0] <= ictl_ff;
         trem_ff[0] <= DW'(tnum[ntc_pkg::NUM_W-1 -: HW]);
         tbit_ff[0] <= tnum[TW-1:0];
         tquo_ff[0] <= '0;
         tdvs_ff[0] <= inv_ff[DW-1:0];
         tovf_ff[0] <= DW'(tnum[ntc_pkg::NUM_W-1 -: HW]) >= inv_ff[DW-1:0];
      end
   end

   for (genvar s = 1; s <= TS; s++) begin : g_tdiv
      logic [DW-1:0] rem_in;
      logic [TW-1:0] bit_in;
      logic [TW-1:0] quo_in;

      always_comb begin
         logic [DW:0] trial;
         rem_in = trem_ff[s-1];
         bit_in = tbit_ff[s-1];
         quo_in = tquo_ff[s-1];
         for (int k = 0; k < ntc_pkg::TDIV_STEPS; k++) begin
            trial  = {rem_in, bit_in[TW-1]};
            bit_in = {bit_in[TW-2:0], 1'b0};
            if (trial >= {1'b0, tdvs_ff[s-1]}) begin
               trial  = trial - {1'b0, tdvs_ff[s-1]};
               quo_in = {quo_in[TW-2:0], 1'b1};
            end else begin
               quo_in = {quo_in[TW-2:0], 1'b0};
            end
            rem_in = trial[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tctl_ff[s].valid <= 1'b0;
         end else if (adv) begin
            tctl_ff[s] <= tctl_ff[s-1];
            trem_ff[s] <= rem_in;
            tbit_ff[s] <= bit_in;
            tquo_ff[s] <= quo_in;
            tdvs_ff[s] <= tdvs_ff[s-1];
            tovf_ff[s] <= tovf_ff[s-1];
         end
      end
   end

   assign tmk     = tquo_ff[TS];
   assign tmk_ovf = tovf_ff[TS];
   assign tmk_ctl = tctl_ff[TS];

endmodule

// ===== rtl/core/thermistor_beta_to_temperature.sv =====
`timescale 1ns / 1ps
// thermistor_beta_to_temperature: ntc beta-equation converter top level
// depends on ntc_pkg, ntc_if, ntc_resist, ntc_log, ntc_recip
//
//   channel   dir   role                     fields
//   req_chan  in    divider voltage items    channel, sample
//   rsp_chan  out   temperature items        channel_out, temperature, status
//   csr_chan  in    register writes          index, data
//
// one item per cycle sustained while rsp_chan does not stall; pipeline depth is
// set by the 24 squaring stages of the log2 lanes and the three restoring
// dividers (resistance, ln/beta, reciprocal)
// reset is synchronous and clears every stage valid bit and the registers
// a stall at rsp_chan freezes the whole pipe; the entry stage still takes
// one item while empty, so req_chan sees ready while a result waits
module thermistor_beta_to_temperature (
   input  logic          clock,
   input  logic          reset,
   ntc_req_if.sink       req_chan,
   ntc_rsp_if.source     rsp_chan,
   ntc_csr_if.sink       csr_chan
);

   // configuration registers
   logic [ntc_pkg::R1_W-1:0]    series_ff;
   logic [ntc_pkg::VREF_W-1:0]  vref_ff;
   logic [ntc_pkg::R25_W-1:0]   nominal_ff;
   logic [ntc_pkg::BETA_W-1:0]  beta_ff;
   logic [ntc_pkg::R25_W-1:0]   nominal_eff;
   logic [ntc_pkg::BETA_W-1:0]  beta_eff;
   logic                        csr_write;

   // pipeline glue
   logic                        adv;
   logic                        entry_free;
   logic                        item_in;
   logic [ntc_pkg::RES_W-1:0]   res_q;
   ntc_pkg::ctl_type            res_ctl;
   logic [ntc_pkg::LN_W-1:0]    ln_mag;
   logic                        ln_neg;
   ntc_pkg::ctl_type            ln_ctl;
   logic [ntc_pkg::TMK_W-1:0]   tmk;
   logic                        tmk_ovf;
   ntc_pkg::ctl_type            tmk_ctl;

   // output register
   logic                                rsp_valid_ff;
   logic [ntc_pkg::CH_W-1:0]            rsp_channel_ff;
   logic signed [ntc_pkg::TEMP_W-1:0]   rsp_temp_ff;
   ntc_pkg::status_type                 rsp_status_ff;
   logic signed [ntc_pkg::TEMP_W-1:0]   temp_in;
   logic [ntc_pkg::TMK_W:0]             celsius;

   assign csr_chan.ready = 1'b1;
   assign csr_write      = csr_chan.valid && csr_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         series_ff  <= ntc_pkg::SERIES_RESET;
         vref_ff    <= ntc_pkg::VREF_RESET;
         nominal_ff <= ntc_pkg::NOMINAL_RESET;
         beta_ff    <= ntc_pkg::BETA_RESET;
      end else if (csr_write) begin
         case (csr_chan.index)
            ntc_pkg::REG_SERIES:  series_ff  <= csr_chan.data[ntc_pkg::R1_W-1:0];
            ntc_pkg::REG_VREF:    vref_ff    <= csr_chan.data[ntc_pkg::VREF_W-1:0];
            ntc_pkg::REG_NOMINAL: nominal_ff <= csr_chan.data[ntc_pkg::R25_W-1:0];
            ntc_pkg::REG_BETA:    beta_ff    <= csr_chan.data[ntc_pkg::BETA_W-1:0];
            default: ;
         endcase
      end
   end

   // zero nominal or beta registers act as one
   assign nominal_eff = (nominal_ff == '0) ? ntc_pkg::R25_W'(1) : nominal_ff;
   assign beta_eff    = (beta_ff == '0) ? ntc_pkg::BETA_W'(1) : beta_ff;

   // whole pipe moves when the output register is empty or being drained
   assign adv            = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv || entry_free;
   assign item_in        = req_chan.valid && req_chan.ready &&
                           ({1'b0, req_chan.channel} < 9'(ntc_pkg::CHANNELS));

   ntc_resist u_resist (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .in_valid   (item_in),
      .in_channel (req_chan.channel),
      .in_sample  (req_chan.sample),
      .series_res (series_ff),
      .ref_volt   (vref_ff),
      .entry_free (entry_free),
      .res_q      (res_q),
      .res_ctl    (res_ctl)
   );

   ntc_log u_log (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_res  (res_q),
      .in_ctl  (res_ctl),
      .nominal (nominal_eff),
      .ln_mag  (ln_mag),
      .ln_neg  (ln_neg),
      .ln_ctl  (ln_ctl)
   );

   ntc_recip u_recip (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ln_mag  (ln_mag),
      .ln_neg  (ln_neg),
      .ln_ctl  (ln_ctl),
      .beta    (beta_eff),
      .tmk     (tmk),
      .tmk_ovf (tmk_ovf),
      .tmk_ctl (tmk_ctl)
   );

   // kelvin to celsius, with open, short and out-of-range handling
   assign celsius = {1'b0, tmk} - ntc_pkg::ZERO_C_MK;

   always_comb begin
      if (tmk_ctl.status == ntc_pkg::ST_OPEN) begin
         temp_in = ntc_pkg::TEMP_MIN;
      end else if (tmk_ctl.status == ntc_pkg::ST_SHORT || tmk_ctl.force_max ||
                   tmk_ovf || (tmk > ntc_pkg::TMK_MAX)) begin
         temp_in = ntc_pkg::TEMP_MAX;
      end else begin
         temp_in = celsius[ntc_pkg::TEMP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff   <= tmk_ctl.valid;
         rsp_channel_ff <= tmk_ctl.channel;
         rsp_temp_ff    <= temp_in;
         rsp_status_ff  <= tmk_ctl.status;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.channel_out = rsp_channel_ff;
   assign rsp_chan.temperature = rsp_temp_ff;
   assign rsp_chan.status      = rsp_status_ff;

   // open input always reports the lowest temperature
   a_open_min: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ntc_pkg::ST_OPEN |->
      rsp_temp_ff == ntc_pkg::TEMP_MIN)
      else $error("open input without minimum temperature");

   // shorted input always reports the highest temperature
   a_short_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ntc_pkg::ST_SHORT |->
      rsp_temp_ff == ntc_pkg::TEMP_MAX)
      else $error("shorted input without maximum temperature");

   // an empty output register never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("input stalled with empty output register");

   // a series resistor write lands in its register
   a_series_write: assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_chan.index == ntc_pkg::REG_SERIES |=>
      series_ff == $past(csr_chan.data[ntc_pkg::R1_W-1:0]))
      else $error("series resistor write lost");

endmodule

// ===== test/tb_thermistor_beta_to_temperature.sv =====
`timescale 1ns / 1ps
// tb_thermistor_beta_to_temperature: self-checking bench for the ntc beta-equation
// converter; bit-exact fixed-point predictor, directed table then random samples
// depends on ntc_pkg, ntc_if and the thermistor_beta_to_temperature rtl
module tb_thermistor_beta_to_temperature;

   // items carry a channel and a divider sample
   typedef struct packed {
      logic [ntc_pkg::CH_W-1:0]  channel;
      logic [ntc_pkg::SMP_W-1:0] sample;
   } sample_item_type;

   // converted temperature, as returned on rsp_chan
   typedef struct packed {
      logic [ntc_pkg::CH_W-1:0]          channel_out;
      logic signed [ntc_pkg::TEMP_W-1:0] temperature;
      ntc_pkg::status_type               status;
   } temp_item_type;

   // one row of the directed table; fixed marks a hand-typed expectation
   typedef struct {
      sample_item_type item;
      bit              fixed;
      temp_item_type   want;
   } table_row_type;

   localparam int LATENCY     = 58;
   localparam int WATCH_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ntc_req_if req_chan ();
   ntc_rsp_if rsp_chan ();
   ntc_csr_if csr_chan ();

   thermistor_beta_to_temperature u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor copy of the register file
   logic [ntc_pkg::R1_W-1:0]   series_ohms;
   logic [ntc_pkg::VREF_W-1:0] vref_units;
   logic [ntc_pkg::R25_W-1:0]  nominal_ohms;
   logic [ntc_pkg::BETA_W-1:0] beta_kelvin;

   temp_item_type expected_temps[$];
   int       error_count = 0;
   int       idle_cycles = 0;
   int       send_idle_pct = 0;
   int       recv_stall_pct = 0;

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // log2 in q8.24 of a nonzero 32-bit value, squaring the normalized mantissa
   function automatic logic [31:0] log2_q824(input logic [31:0] v);
      int          msb;
      logic [63:0] mant;
      logic [23:0] frac;
      msb = 31;
      frac = '0;
      while (v[msb] == 1'b0) msb--;
      mant = 64'(v) << (31 - msb);
      for (int i = 0; i < 24; i++) begin
         mant = (mant * mant) >> 31;
         frac = frac << 1;
         if (mant >= 64'h1_0000_0000) begin
            frac[0] = 1'b1;
            mant = mant >> 1;
         end
      end
      return {8'(msb), frac};
   endfunction

   // temperature in milli-degrees for a sample strictly between 0 and vref
   function automatic longint beta_temperature(input logic [ntc_pkg::SMP_W-1:0] v);
      logic [63:0] res;
      logic [31:0] r25;
      logic [63:0] beta;
      longint      diff;
      longint      inv;
      logic [63:0] mag;
      logic [63:0] ln_mag;
      logic [63:0] quot;
      logic [63:0] tmk;
      r25  = (nominal_ohms == 0) ? 32'd1 : 32'(nominal_ohms);
      beta = (beta_kelvin == 0) ? 64'd1 : 64'(beta_kelvin);
      res = ((64'(series_ohms) * 64'(v)) << 8) / 64'(vref_units - v);
      if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
      if (res == 0) return longint'(ntc_pkg::TEMP_MAX);
      diff = longint'(log2_q824(res[31:0])) - longint'(log2_q824(r25 << 8));
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      ln_mag = (mag * 64'd744261118) >> 30;
      quot = (ln_mag << 16) / beta;
      inv = (diff < 0) ? 64'sd3687780070 - longint'(quot)
                       : 64'sd3687780070 + longint'(quot);
      if (inv <= 0) return longint'(ntc_pkg::TEMP_MAX);
      tmk = ((64'd1000 << 40) + (64'(inv) >> 1)) / 64'(inv);
      if (tmk > 64'd797437) return longint'(ntc_pkg::TEMP_MAX);
      diff = longint'(tmk) - 273150;
      if (diff < -273150) diff = -273150;
      return diff;
   endfunction

   function automatic temp_item_type predict_temp(input sample_item_type it);
      temp_item_type t;
      t.channel_out = it.channel;
      if (32'(it.sample) >= 32'(vref_units)) begin
         t.status = ntc_pkg::ST_OPEN;
         t.temperature = ntc_pkg::TEMP_MIN;
      end else if (it.sample == 0) begin
         t.status = ntc_pkg::ST_SHORT;
         t.temperature = ntc_pkg::TEMP_MAX;
      end else begin
         t.status = ntc_pkg::ST_VALID;
         t.temperature = ntc_pkg::TEMP_W'(beta_temperature(it.sample));
      end
      return t;
   endfunction

   // drive idle values from time zero
   initial begin
      req_chan.valid = 1'b0;
      req_chan.channel = '0;
      req_chan.sample = '0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
   end

   // receiver: random stall at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // checker and watchdog at the rising edge
   always @(posedge clock) begin
      temp_item_type got;
      temp_item_type want;
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
             || (csr_chan.valid && csr_chan.ready)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.channel_out = rsp_chan.channel_out;
            got.temperature = rsp_chan.temperature;
            got.status = ntc_pkg::status_type'(rsp_chan.status);
            if (expected_temps.size() == 0) begin
               report_mismatch("unexpected item, channel", got.channel_out, -1);
            end else begin
               want = expected_temps.pop_front();
               if (got.channel_out !== want.channel_out)
                  report_mismatch("channel_out", got.channel_out, want.channel_out);
               if (got.temperature !== want.temperature)
                  report_mismatch("temperature", got.temperature, want.temperature);
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
            end
         end
         if (idle_cycles >= WATCH_LIMIT) begin
            $display("[thermistor_beta_to_temperature] ERROR");
            $finish;
         end
      end
   end

   // one register write; the predictor copy follows the same masking
   task automatic write_register(input logic [ntc_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [23:0] val);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= val;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         ntc_pkg::REG_SERIES:  series_ohms = val;
         ntc_pkg::REG_VREF:    vref_units = val[ntc_pkg::VREF_W-1:0];
         ntc_pkg::REG_NOMINAL: nominal_ohms = val;
         ntc_pkg::REG_BETA:    beta_kelvin = val[ntc_pkg::BETA_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // send one sample item; predicted at acceptance, valid stays up for the next
   task automatic send_sample(input sample_item_type it, input bit fixed,
                              input temp_item_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.channel <= it.channel;
      req_chan.sample <= it.sample;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_temps.push_back(fixed ? want : predict_temp(it));
      @(negedge clock);
   endtask

   // wait out all results plus pipeline tail before touching registers
   task automatic drain_pipe();
      req_chan.valid <= 1'b0;
      while (expected_temps.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic sample_item_type rand_sample();
      sample_item_type it;
      int pick;
      it.channel = 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 70 && vref_units > 1)
         it.sample = ntc_pkg::SMP_W'($urandom_range(32'(vref_units) - 1, 1));
      else if (pick < 80) it.sample = 23'($urandom);
      else if (pick < 85) it.sample = '0;
      else if (pick < 90) it.sample = vref_units;
      else if (pick < 95) it.sample = 23'h7FFFFF;
      else it.sample = ntc_pkg::SMP_W'(1 << $urandom_range(22));
      return it;
   endfunction

   task automatic random_phase(input int count);
      temp_item_type none;
      none = '0;
      for (int i = 0; i < count; i++) begin
         send_sample(rand_sample(), 1'b0, none);
         // idling mix: receiver-heavy, then sender-heavy, then none
         if (i == count / 3) begin
            send_idle_pct = 85; recv_stall_pct = 12;
         end else if (i == 2 * count / 3) begin
            send_idle_pct = 0; recv_stall_pct = 0;
         end
      end
   endtask

   task automatic new_settings(input logic [23:0] r1, input logic [23:0] vref,
                               input logic [23:0] r25, input logic [23:0] beta);
      drain_pipe();
      write_register(ntc_pkg::REG_SERIES, r1);
      write_register(ntc_pkg::REG_VREF, vref);
      write_register(ntc_pkg::REG_NOMINAL, r25);
      write_register(ntc_pkg::REG_BETA, beta);
   endtask

   initial begin
      table_row_type rows[$];
      table_row_type row;
      temp_item_type none;
      none = '0;
      series_ohms = ntc_pkg::SERIES_RESET;
      vref_units = ntc_pkg::VREF_RESET;
      nominal_ohms = ntc_pkg::NOMINAL_RESET;
      beta_kelvin = ntc_pkg::BETA_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 12;
      recv_stall_pct = 85;

      // directed rows: after reset, open / short / extremes / midpoint
      row.fixed = 1'b1;
      row.item = '{8'd0, 23'd0};
      row.want = '{8'd0, ntc_pkg::TEMP_MAX, ntc_pkg::ST_SHORT};
      rows.push_back(row);
      row.item = '{8'd255, 23'd5000000};
      row.want = '{8'd255, ntc_pkg::TEMP_MIN, ntc_pkg::ST_OPEN};
      rows.push_back(row);
      row.item = '{8'd7, 23'h7FFFFF};
      row.want = '{8'd7, ntc_pkg::TEMP_MIN, ntc_pkg::ST_OPEN};
      rows.push_back(row);
      row.fixed = 1'b0;
      row.want = none;
      row.item = '{8'd1, 23'd2500000}; rows.push_back(row);   // r equals r25, near 25 c
      row.item = '{8'd2, 23'd1};       rows.push_back(row);   // tiny resistance, hot end
      row.item = '{8'd3, 23'd4999999}; rows.push_back(row);   // huge resistance saturates
      row.item = '{8'd128, 23'd1000000}; rows.push_back(row);
      row.item = '{8'd85, 23'h2AAAAA};  rows.push_back(row);
      row.item = '{8'd170, 23'h555555}; rows.push_back(row);
      row.item = '{8'd4, 23'd4000000}; rows.push_back(row);
      foreach (rows[i]) send_sample(rows[i].item, rows[i].fixed, rows[i].want);

      // zero series and zero nominal/beta registers, maximum vref
      new_settings(24'd0, 24'h7FFFFF, 24'd0, 24'd0);
      send_sample('{8'd9, 23'd100}, 1'b0, none);
      send_sample('{8'd10, 23'h7FFFFE}, 1'b0, none);
      send_sample('{8'd11, 23'h7FFFFF}, 1'b1,
                  '{8'd11, ntc_pkg::TEMP_MIN, ntc_pkg::ST_OPEN});
      // zero reference voltage makes even a zero sample open
      new_settings(24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'hFFFF);
      send_sample('{8'd12, 23'd0}, 1'b1, '{8'd12, ntc_pkg::TEMP_MIN, ntc_pkg::ST_OPEN});
      drain_pipe();
      write_register(8'd4, 24'h123456);   // index past the map, ignored
      write_register(8'hFF, 24'hABCDEF);
      new_settings(24'hFFFFFF, 24'h7FFFFF, 24'd1, 24'd1);
      send_sample('{8'd13, 23'h400000}, 1'b0, none);
      send_sample('{8'd14, 23'd1}, 1'b0, none);
      new_settings(24'd1, 24'h7FFFFF, 24'hFFFFFF, 24'hFFFF);
      send_sample('{8'd15, 23'd1}, 1'b0, none);

      // random phases across several settings
      new_settings(ntc_pkg::SERIES_RESET, ntc_pkg::VREF_RESET,
                   ntc_pkg::NOMINAL_RESET, ntc_pkg::BETA_RESET);
      random_phase(RANDOM_ITEMS / 2);
      send_idle_pct = 12; recv_stall_pct = 85;
      new_settings(24'($urandom_range(100000, 100)), 24'($urandom_range(8388607, 1000)),
                   24'($urandom_range(100000, 100)), 24'($urandom_range(5000, 1000)));
      random_phase(RANDOM_ITEMS / 4);
      send_idle_pct = 12; recv_stall_pct = 85;
      new_settings(24'($urandom), 24'($urandom_range(8388607, 1)),
                   24'($urandom), 24'($urandom_range(65535, 0)));
      random_phase(RANDOM_ITEMS / 4);

      drain_pipe();
      if (error_count == 0) $display("[thermistor_beta_to_temperature] OK");
      else $display("[thermistor_beta_to_temperature] ERROR");
      $finish;
   end

endmodule
